>>> rtl/upe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers of the URL percent encoder.
package upe_pkg;

   // Longest string whose byte offsets are counted; offsets saturate below.
   localparam longint unsigned MAX_STRING_LENGTH = 64'd65535;
   localparam logic [15:0] POS_LIMIT = (MAX_STRING_LENGTH < 64'd65535) ?
                                       16'(MAX_STRING_LENGTH) : 16'hFFFF;

   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] PLUS_CHAR    = 8'h2B;
   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;

   localparam logic [2:0] LEAD2_CODE = 3'b110;
   localparam logic [3:0] LEAD3_CODE = 4'b1110;
   localparam logic [4:0] LEAD4_CODE = 5'b11110;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_HEX,
      KIND_CODE_POINT,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic accept;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic has_results;
      logic last_result;
   } status_type;

   function automatic logic is_reserved(input logic [7:0] b);
      logic hit;
      unique case (b)
         8'h21, 8'h23, 8'h24, 8'h26, 8'h22, 8'h27, 8'h28, 8'h29, 8'h2A,
         8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B,
         8'h5D:   hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // 0 means the byte cannot start a code point
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      priority if (b[7] == 1'b0)       len = 3'd1;
      else if (b[7:5] == LEAD2_CODE)   len = 3'd2;
      else if (b[7:4] == LEAD3_CODE)   len = 3'd3;
      else if (b[7:3] == LEAD4_CODE)   len = 3'd4;
      else                             len = 3'd0;
      return len;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) c = {4'h3, n};
      else           c = 8'h37 + {4'h0, n};
      return c;
   endfunction

endpackage

>>> rtl/url_percent_encoder.sv
`timescale 1ns / 1ps
// Top level of the form-style URL percent encoder.
//
// Takes one string byte per req_ transaction (req_string_end marks the last
// byte) and returns the encoded characters one per rsp_ transaction: a space
// becomes '+', control bytes and the reserved set become %XX, other ASCII
// passes through, and a complete UTF-8 code point of 2 to 4 bytes comes out
// as %XX for every byte. Bad lead bytes and cut-off code points give one
// error transaction with the lead byte's offset; the rest of that string is
// then dropped silently. An input transaction is taken while the block is idle;
// it then streams its 0 to 12 results at one per cycle while rsp_ready is
// high, and takes the next byte in the cycle after the final result goes out.
// A byte with no results leaves the block idle and ready for the next byte.
module url_percent_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_error,
   output logic [15:0] rsp_error_position,
   output logic        rsp_run_last,
   output logic        rsp_string_done
);
   import upe_pkg::*;

   cmd_type    cmd;
   status_type status;

   // handshake control and result sequencing
   upe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // byte classification, string state and result generation
   upe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_in_byte        (req_in_byte),
      .req_string_end     (req_string_end),
      .rsp_out_char       (rsp_out_char),
      .rsp_is_error       (rsp_is_error),
      .rsp_error_position (rsp_error_position),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_done    (rsp_string_done)
   );

endmodule

>>> rtl/upe_ctrl.sv
`timescale 1ns / 1ps
// Controller of the URL percent encoder: input acceptance and result sequencing.
module upe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  upe_pkg::status_type  status,
   output upe_pkg::cmd_type     cmd
);
   import upe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.has_results) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && status.last_result) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EMIT: rsp_valid = 1'b1;
         default: ;
      endcase
      cmd.accept  = req_ready && req_valid;
      cmd.advance = rsp_valid && rsp_ready;
   end

endmodule

>>> rtl/upe_datapath.sv
`timescale 1ns / 1ps
// Datapath of the URL percent encoder: string state, code point buffer, result plan.
module upe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  upe_pkg::cmd_type    cmd,
   output upe_pkg::status_type status,
   input  logic [7:0]          req_in_byte,
   input  logic                req_string_end,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_is_error,
   output logic [15:0]         rsp_error_position,
   output logic                rsp_run_last,
   output logic                rsp_string_done
);
   import upe_pkg::*;

   // string state
   logic [7:0]  buf_mem [4];
   logic [2:0]  exp_ff, exp_in;
   logic [2:0]  held_ff, held_in;
   logic [15:0] pos_ff, pos_in;
   logic        skip_ff, skip_in;
   logic [15:0] lead_ff, lead_in;

   // result plan
   kind_type    kind_ff, kind_in;
   logic [7:0]  char_ff, char_in;
   logic [15:0] epos_ff, epos_in;
   logic        done_ff, done_in;
   logic [2:0]  elen_ff, elen_in;
   logic [1:0]  idx_ff, idx_in;
   logic [1:0]  digit_ff, digit_in;

   logic        buf_we;
   logic [1:0]  buf_widx;
   logic        has_res;
   logic        err;
   logic [2:0]  len;
   logic [2:0]  held_next;
   logic [7:0]  hex_src;
   logic        last_res;

   always_comb begin
      kind_in   = kind_ff;
      char_in   = char_ff;
      epos_in   = epos_ff;
      elen_in   = elen_ff;
      held_in   = held_ff;
      exp_in    = exp_ff;
      lead_in   = lead_ff;
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      buf_we    = 1'b0;
      buf_widx  = held_ff[1:0];
      has_res   = 1'b0;
      err       = 1'b0;
      len       = lead_length(req_in_byte);
      held_next = held_ff + 3'd1;

      if (!skip_ff) begin
         if (held_ff != 3'd0) begin
            buf_we = 1'b1;
            if (held_next >= exp_ff) begin
               kind_in = KIND_CODE_POINT;
               elen_in = exp_ff;
               has_res = 1'b1;
               held_in = 3'd0;
               exp_in  = 3'd0;
            end else begin
               held_in = held_next;
               if (req_string_end) begin
                  kind_in = KIND_ERROR;
                  epos_in = lead_ff;
                  has_res = 1'b1;
                  err     = 1'b1;
               end
            end
         end else if (req_in_byte == SPACE_CHAR) begin
            kind_in = KIND_CHAR;
            char_in = PLUS_CHAR;
            has_res = 1'b1;
         end else if (len == 3'd0) begin
            kind_in = KIND_ERROR;
            epos_in = pos_ff;
            has_res = 1'b1;
            err     = 1'b1;
         end else if (len == 3'd1) begin
            char_in = req_in_byte;
            has_res = 1'b1;
            if (req_in_byte <= CTRL_MAX || is_reserved(req_in_byte)) kind_in = KIND_HEX;
            else                                                     kind_in = KIND_CHAR;
         end else begin
            buf_we   = 1'b1;
            buf_widx = 2'd0;
            held_in  = 3'd1;
            exp_in   = len;
            lead_in  = pos_ff;
            if (req_string_end) begin
               kind_in = KIND_ERROR;
               epos_in = pos_ff;
               has_res = 1'b1;
               err     = 1'b1;
            end
         end
         if (!req_string_end) begin
            if (err) begin
               skip_in = 1'b1;
               held_in = 3'd0;
               exp_in  = 3'd0;
            end
            if (pos_ff < POS_LIMIT) pos_in = pos_ff + 16'd1;
         end
      end

      // string end clears the held count, expected length, offsets and skip flag for the next string
      if (req_string_end) begin
         held_in = 3'd0;
         exp_in  = 3'd0;
         pos_in  = 16'd0;
         skip_in = 1'b0;
         lead_in = 16'd0;
      end
      done_in = req_string_end || err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= 3'd0;
         held_ff <= 3'd0;
         pos_ff  <= 16'd0;
         skip_ff <= 1'b0;
         lead_ff <= 16'd0;
      end else if (cmd.accept) begin
         exp_ff  <= exp_in;
         held_ff <= held_in;
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         lead_ff <= lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && buf_we) buf_mem[buf_widx] <= req_in_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_CHAR;
         char_ff <= 8'd0;
         epos_ff <= 16'd0;
         done_ff <= 1'b0;
         elen_ff <= 3'd0;
      end else if (cmd.accept) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         epos_ff <= epos_in;
         done_ff <= done_in;
         elen_ff <= elen_in;
      end
   end

   // step through the digits of each hex-encoded byte
   always_comb begin
      idx_in   = idx_ff;
      digit_in = digit_ff;
      if (cmd.accept) begin
         idx_in   = 2'd0;
         digit_in = 2'd0;
      end else if (cmd.advance) begin
         if (digit_ff == 2'd2) begin
            digit_in = 2'd0;
            idx_in   = idx_ff + 2'd1;
         end else begin
            digit_in = digit_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         digit_ff <= 2'd0;
      end else begin
         idx_ff   <= idx_in;
         digit_ff <= digit_in;
      end
   end

   always_comb begin
      hex_src  = (kind_ff == KIND_CODE_POINT) ? buf_mem[idx_ff] : char_ff;
      last_res = 1'b1;
      rsp_out_char       = 8'd0;
      rsp_is_error       = 1'b0;
      rsp_error_position = 16'd0;
      unique case (kind_ff)
         KIND_CHAR: rsp_out_char = char_ff;
         KIND_ERROR: begin
            rsp_is_error       = 1'b1;
            rsp_error_position = epos_ff;
         end
         KIND_HEX, KIND_CODE_POINT: begin
            unique case (digit_ff)
               2'd0:    rsp_out_char = PERCENT_CHAR;
               2'd1:    rsp_out_char = hex_char(hex_src[7:4]);
               default: rsp_out_char = hex_char(hex_src[3:0]);
            endcase
            last_res = (digit_ff == 2'd2) &&
                       ((kind_ff == KIND_HEX) || ({1'b0, idx_ff} == elen_ff - 3'd1));
         end
         default: ;
      endcase
      rsp_run_last    = last_res;
      rsp_string_done = last_res && done_ff;
   end

   assign status.has_results = has_res;
   assign status.last_result = last_res;

endmodule

>>> sim/url_percent_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the URL percent encoder: directed strings and random strings.
module url_percent_encoder_tb;
   import upe_pkg::*;

   localparam int IDLE_PCT       = 27;     // chance in 100 that a side idles in a cycle
   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transaction before giving up
   localparam int RANDOM_ITEMS   = 185;    // directed strings add about 26 more bytes
   localparam int STEADY_FROM    = 20;     // random bytes sent before the no-idle stretch
   localparam int STEADY_SPAN    = 40;
   localparam int PRESSURE_AFTER = 80;     // random bytes sent before the receiver stall
   localparam int RX_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES   = 20;     // extra wait after all owed characters have come out

   // One encoded character as it leaves the rsp_ channel.
   typedef struct packed {
      logic [7:0]  ch;
      logic        is_err;
      logic [15:0] pos;
      logic        run_last;
      logic        done;
   } enc_char_type;

   // Tracks the encoder state on the side and keeps the characters still owed by the block.
   class encode_scoreboard;
      enc_char_type char_q[$];
      enc_char_type burst[12];
      int          burst_len;
      logic [7:0]  cp_bytes[4];
      logic [2:0]  cp_len;
      logic [2:0]  held;
      logic [15:0] offset;
      logic [15:0] lead_offset;
      bit          skipping;
      int          mismatches;
      int          chars_checked;
      int          errors_seen;
      int          strings_seen;
      string       reserved_marks = "!#$&\"'()*+,/:;=?@[]";

      function new();
         clear_string();
         mismatches    = 0;
         chars_checked = 0;
         errors_seen   = 0;
         strings_seen  = 0;
      endfunction

      function void clear_string();
         cp_len      = 3'd0;
         held        = 3'd0;
         offset      = 16'd0;
         lead_offset = 16'd0;
         skipping    = 1'b0;
      endfunction

      function bit reserved_mark(logic [7:0] b);
         for (int i = 0; i < reserved_marks.len(); i++)
            if (reserved_marks[i] == b) return 1'b1;
         return 1'b0;
      endfunction

      function logic [7:0] hex_digit(logic [3:0] n);
         return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h41 + {4'h0, n} - 8'd10;
      endfunction

      function void add_char(logic [7:0] ch, logic err, logic [15:0] pos);
         burst[burst_len] = '{ch, err, pos, 1'b0, 1'b0};
         burst_len++;
      endfunction

      function void add_hex(logic [7:0] b);
         add_char(PERCENT_CHAR, 1'b0, 16'd0);
         add_char(hex_digit(b[7:4]), 1'b0, 16'd0);
         add_char(hex_digit(b[3:0]), 1'b0, 16'd0);
      endfunction

      // Work out the characters one accepted byte owes and queue them.
      function void note_byte(logic [7:0] b, logic last);
         logic [2:0] len;
         bit         err;
         if (skipping) begin
            if (last) begin
               clear_string();
               strings_seen++;
            end
            return;
         end
         burst_len = 0;
         err = 1'b0;
         if (held != 3'd0) begin
            cp_bytes[held[1:0]] = b;
            held = held + 3'd1;
            if (held >= cp_len) begin
               for (int i = 0; i < cp_len; i++) add_hex(cp_bytes[i]);
               held   = 3'd0;
               cp_len = 3'd0;
            end else if (last) begin
               add_char(8'h00, 1'b1, lead_offset);
               err = 1'b1;
            end
         end else if (b == SPACE_CHAR) begin
            add_char(PLUS_CHAR, 1'b0, 16'd0);
         end else begin
            casez (b)
               8'b0???????: len = 3'd1;
               8'b110?????: len = 3'd2;
               8'b1110????: len = 3'd3;
               8'b11110???: len = 3'd4;
               default:     len = 3'd0;
            endcase
            if (len == 3'd0) begin
               add_char(8'h00, 1'b1, offset);
               err = 1'b1;
            end else if (len == 3'd1) begin
               if (b <= CTRL_MAX || reserved_mark(b)) add_hex(b);
               else add_char(b, 1'b0, 16'd0);
            end else begin
               cp_bytes[0] = b;
               held        = 3'd1;
               cp_len      = len;
               lead_offset = offset;
               if (last) begin
                  add_char(8'h00, 1'b1, offset);
                  err = 1'b1;
               end
            end
         end
         if (burst_len > 0) begin
            burst[burst_len - 1].run_last = 1'b1;
            burst[burst_len - 1].done     = last || err;
         end
         for (int i = 0; i < burst_len; i++) char_q.push_back(burst[i]);
         if (err) errors_seen++;
         if (last) begin
            clear_string();
            strings_seen++;
         end else begin
            if (err) begin
               skipping = 1'b1;
               held     = 3'd0;
               cp_len   = 3'd0;
            end
            if (offset < POS_LIMIT) offset = offset + 16'd1;
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one delivered character against the oldest one owed.
      function void check_char(enc_char_type got);
         enc_char_type want;
         if (char_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual char %0h error %b pos %0d",
                     $time, got.ch, got.is_err, got.pos);
            mismatches++;
            return;
         end
         want = char_q.pop_front();
         chars_checked++;
         compare_field("out_char", want.ch, got.ch);
         compare_field("is_error", want.is_err, got.is_err);
         compare_field("error_position", want.pos, got.pos);
         compare_field("run_last", want.run_last, got.run_last);
         compare_field("string_done", want.done, got.done);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_string_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_char;
   logic        rsp_is_error;
   logic [15:0] rsp_error_position;
   logic        rsp_run_last;
   logic        rsp_string_done;

   encode_scoreboard sb;
   enc_char_type     seen;
   logic [7:0]       str_bytes[$];   // string being assembled for the sender
   bit               steady = 1'b0;  // no idling on either side while set
   bit               hold_request = 1'b0;
   bit               pressure_done = 1'b0;
   int               quiet_cycles = 0;
   int               bytes_sent = 0;
   int               random_items = 0;

   url_percent_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_string_end     (req_string_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_is_error       (rsp_is_error),
      .rsp_error_position (rsp_error_position),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_done    (rsp_string_done)
   );

   always #2 clock = ~clock;

   // Receiver: drop ready at random, or for a long stretch when the stimulus asks for it.
   // The stretch is counted here so the sender keeps offering bytes meanwhile.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (RX_HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: sample both channels at the falling edge, where all signals have settled.
   // A handshake seen here completes at the next rising edge. Results are checked
   // before the byte is noted; a byte accepted at this edge cannot have produced
   // anything yet. The same block runs the watchdog.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_out_char, rsp_is_error, rsp_error_position, rsp_run_last,
                     rsp_string_done};
            sb.check_char(seen);
         end
         if (req_valid && req_ready) begin
            sb.note_byte(req_in_byte, req_string_end);
            bytes_sent++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offer one byte and return at the rising edge where it is taken. Valid stays
   // high on return so back-to-back bytes never toggle it within one time step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_string_end <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Send the assembled string, end mark on its final byte, then drop it.
   task automatic send_string();
      for (int i = 0; i < str_bytes.size(); i++)
         send_byte(str_bytes[i], i == str_bytes.size() - 1);
      random_items += str_bytes.size();
      str_bytes.delete();
   endtask

   // Hold the sender until every owed character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.char_q.size() != 0) @(posedge clock);
   endtask

   // Append a lead byte of the given code point length and keep-1 continuation bytes.
   // Continuation bytes are fully random: the block does not check them.
   function automatic void add_code_point(int len, int keep);
      logic [31:0] r;
      r = $urandom;
      case (len)
         2:       str_bytes.push_back({LEAD2_CODE, r[4:0]});
         3:       str_bytes.push_back({LEAD3_CODE, r[3:0]});
         default: str_bytes.push_back({LEAD4_CODE, r[2:0]});
      endcase
      for (int i = 1; i < keep; i++) str_bytes.push_back(8'($urandom));
   endfunction

   // Mostly well-formed text with code points; a share of bad lead bytes and cut-off
   // code points so the error and skip paths get exercised too.
   function automatic void build_random_string();
      int          tokens;
      int          pick;
      int          len;
      logic [31:0] r;
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         pick = $urandom_range(99);
         r = $urandom;
         if (pick < 28)
            str_bytes.push_back({1'b0, r[6:0]});
         else if (pick < 36)
            str_bytes.push_back(SPACE_CHAR);
         else if (pick < 42)
            str_bytes.push_back({3'b000, r[4:0]});
         else if (pick < 48)
            str_bytes.push_back(sb.reserved_marks[$urandom_range(0, sb.reserved_marks.len() - 1)]);
         else if (pick < 91) begin
            len = $urandom_range(2, 4);
            add_code_point(len, len);
         end else if (r[8])
            str_bytes.push_back({2'b10, r[5:0]});
         else
            str_bytes.push_back({5'b11111, r[2:0]});
      end
      // Now and then end the string in the middle of a code point.
      if ($urandom_range(99) < 10) begin
         len = $urandom_range(2, 4);
         add_code_point(len, $urandom_range(1, len - 1));
      end
   endfunction

   initial begin
      sb = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_string_end = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Control extremes, space, a reserved mark at each end of the set, DEL.
      str_bytes = '{8'h00, 8'h1F, SPACE_CHAR, 8'h21, 8'h5D, 8'h7F};
      send_string();
      // Complete 2, 3 and 4 byte code points, the last one closing the string.
      str_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_string();
      // A space inside a code point is hex-encoded.
      str_bytes = '{8'hC2, SPACE_CHAR};
      send_string();
      // Invalid lead byte mid-string; the rest of the string is dropped.
      str_bytes = '{8'h41, 8'hFF, 8'h42, 8'h43};
      send_string();
      // Code point cut off by the end of the string.
      str_bytes = '{8'h61, 8'hE2, 8'h82};
      send_string();
      // Lead byte that itself carries the end mark; stray continuation with the end mark.
      str_bytes = '{8'hF4};
      send_string();
      str_bytes = '{8'hBF};
      send_string();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         // A stretch with no idling on either side.
         steady = (random_items >= STEADY_FROM) && (random_items < STEADY_FROM + STEADY_SPAN);
         if (!pressure_done && random_items >= PRESSURE_AFTER) begin
            // Stall the receiver and keep offering, then pause until all has drained.
            pressure_done = 1'b1;
            steady        = 1'b0;
            hold_request  = 1'b1;
            repeat (4) begin
               build_random_string();
               send_string();
            end
            wait_drained();
         end
         build_random_string();
         send_string();
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d characters, %0d of them errors.",
               bytes_sent, sb.strings_seen, sb.chars_checked, sb.errors_seen);
      $display("Run included a stretch of about %0d bytes with no idling and a %0d-cycle stall.",
               STEADY_SPAN, RX_HOLD_CYCLES);
      if (sb.char_q.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.char_q.size());
      if (sb.mismatches == 0 && sb.char_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/upe_pkg.sv
rtl/upe_ctrl.sv
rtl/upe_datapath.sv
rtl/url_percent_encoder.sv
sim/url_percent_encoder_tb.sv
